// ===== hdl/bmhq_pkg.sv =====
// shared types and constants for the binary min-heap queue
package bmhq_pkg;

    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int DATA_BITS_DEF     = 32;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;
    localparam logic [1:0] REG_CAPACITY   = 2'd0;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] priority_req;
        logic [31:0] data_in;
    } item_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [8:0]  count;
        logic        empty_flag;
        logic        is_full;
    } item_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // latch input item
        logic rd_scan;     // issue read at the search pointer
        logic rd_last;     // issue read of the last entry
        logic rd_left;     // issue read of left child
        logic rd_right;    // issue read of right child
        logic rd_parent;   // issue read of parent
        logic cap_last;    // capture last entry as moving value
        logic cap_left;    // capture left child entry
        logic cap_out;     // capture read data for output
        logic set_ok;      // mark the command as successful
        logic step_scan;   // advance search pointer
        logic init_push;   // hole = count+1, inc count
        logic init_rm;     // hole = search pointer, dec count
        logic move_parent; // write parent into hole, hole = parent
        logic move_child;  // write chosen child into hole, hole = child
        logic place;       // write moving value into hole
        logic emit;        // drive result
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic hole_root;     // hole is position 1
        logic up_go;         // moving value smaller than parent
        logic has_left;      // left child exists
        logic has_right;     // right child exists
        logic down_go;       // chosen child smaller than moving value
        logic match;         // scanned entry matches
        logic scan_end;      // search pointer reached count
        logic rm_is_last;    // removed position equals last
    } sts_t;

endpackage

// ===== hdl/bmhq_datapath.sv =====
// heap store, pointers and comparators for the min-heap queue
module bmhq_datapath import bmhq_pkg::*; #(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int DATA_BITS     = DATA_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_t                      ctl,
    output sts_t                      sts,
    input  item_in_t                  item_in,
    input  logic [8:0]                capacity,
    output item_out_t                 item_out,
    output logic                      result_valid
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int PW = $clog2(MAX_ENTRIES + 1) + 1; // positions up to 2*MAX+1
    localparam int EW = PRIORITY_BITS + DATA_BITS;

    logic [EW-1:0]            mem [MAX_ENTRIES];
    logic [EW-1:0]            rd_reg;
    logic [EW-1:0]            left_reg;
    logic [PW-1:0]            count_reg, hole_reg, scan_reg, child_reg;
    logic                     right_reg;
    logic [PRIORITY_BITS-1:0] mv_pri_reg;
    logic [DATA_BITS-1:0]     mv_dat_reg, out_dat_reg, key_reg;
    logic [1:0]               st_reg;
    logic [1:0]               st_load;
    logic                     valid_reg;
    logic                     rd_req;
    logic [PW-1:0]            rd_pos, rd_slot, left_pos, right_pos;
    logic [PW-1:0]            cap_eff;
    logic [PRIORITY_BITS-1:0] rd_pri, left_pri, pick_pri, pin;
    logic [DATA_BITS-1:0]     rd_dat, din;
    logic                     pick_right;
    logic [EW-1:0]            pick_entry;
    logic [PW-1:0]            pick_pos;
    logic [AW-1:0]            wr_addr;

    assign rd_pri = rd_reg[EW-1 -: PRIORITY_BITS];
    assign rd_dat = rd_reg[DATA_BITS-1:0];
    assign pin = PRIORITY_BITS'(item_in.priority_req);
    assign din = DATA_BITS'(item_in.data_in);
    assign left_pos = hole_reg << 1;
    assign right_pos = left_pos + PW'(1);

    // effective capacity saturates at store depth
    always_comb
    begin
        if (int'(capacity) > MAX_ENTRIES)
            cap_eff = PW'(MAX_ENTRIES);
        else
            cap_eff = PW'(capacity);
    end

    // read position select
    always_comb
    begin
        rd_req = 1'b1;
        rd_pos = scan_reg;
        if (ctl.rd_last)
            rd_pos = count_reg;
        else if (ctl.rd_left)
            rd_pos = left_pos;
        else if (ctl.rd_right)
            rd_pos = right_pos;
        else if (ctl.rd_parent)
            rd_pos = hole_reg >> 1;
        else if (ctl.rd_scan)
            rd_pos = scan_reg;
        else
            rd_req = 1'b0;
        rd_slot = rd_pos - PW'(1);
    end

    // child choice: right child, when it was read, taken unless left strictly smaller
    assign left_pri   = left_reg[EW-1 -: PRIORITY_BITS];
    assign pick_right = right_reg && !(left_pri < rd_pri);
    assign pick_entry = pick_right ? rd_reg : left_reg;
    assign pick_pri   = pick_right ? rd_pri : left_pri;
    assign pick_pos   = pick_right ? child_reg + PW'(1) : child_reg;

    // heap store, one write and one registered read a cycle
    assign wr_addr = AW'(hole_reg - PW'(1));
    always_ff @(posedge clk)
    begin
        if (rd_req)
            rd_reg <= mem[rd_slot[AW-1:0]];
        if (ctl.move_parent)
            mem[wr_addr] <= rd_reg;
        else if (ctl.move_child)
            mem[wr_addr] <= pick_entry;
        else if (ctl.place)
            mem[wr_addr] <= {mv_pri_reg, mv_dat_reg};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.emit;
            if (ctl.init_push)
                count_reg <= count_reg + PW'(1);
            else if (ctl.init_rm)
                count_reg <= count_reg - PW'(1);
        end
    end

    // error status preset on load
    always_comb
    begin
        case (item_in.command)
            CMD_PUSH:   st_load = ST_FULL;
            CMD_POP,
            CMD_PEEK:   st_load = ST_EMPTY;
            CMD_DELETE: st_load = ST_NOT_FOUND;
            default:    st_load = ST_NOT_FOUND;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mv_pri_reg <= pin;
            mv_dat_reg <= din;
        end
        else if (ctl.cap_last)
        begin
            mv_pri_reg <= rd_pri;
            mv_dat_reg <= rd_dat;
        end
        if (ctl.load)
            key_reg <= din;
        if (ctl.load)
            st_reg <= st_load;
        else if (ctl.set_ok)
            st_reg <= ST_OK;
        if (ctl.load)
            out_dat_reg <= '0;
        else if (ctl.cap_out)
            out_dat_reg <= rd_dat;
        else if (ctl.init_push)
            out_dat_reg <= mv_dat_reg;
        if (ctl.load)
            scan_reg <= PW'(1);
        else if (ctl.step_scan)
            scan_reg <= scan_reg + PW'(1);
        if (ctl.cap_left)
            left_reg <= rd_reg;
        if (ctl.rd_left)
        begin
            child_reg <= left_pos;
            right_reg <= 1'b0;
        end
        else if (ctl.rd_right)
            right_reg <= 1'b1;
        if (ctl.init_push)
            hole_reg <= count_reg + PW'(1);
        else if (ctl.init_rm)
            hole_reg <= scan_reg;
        else if (ctl.move_parent)
            hole_reg <= hole_reg >> 1;
        else if (ctl.move_child)
            hole_reg <= pick_pos;
    end

    // status flags
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg >= cap_eff);
    assign sts.hole_root  = (hole_reg == PW'(1));
    assign sts.up_go      = (mv_pri_reg < rd_pri);
    assign sts.has_left   = (left_pos <= count_reg);
    assign sts.has_right  = (right_pos <= count_reg);
    assign sts.down_go    = (pick_pri < mv_pri_reg);
    assign sts.match      = (rd_dat == key_reg);
    assign sts.scan_end   = (scan_reg >= count_reg);
    assign sts.rm_is_last = (scan_reg == count_reg);

    // result, data stays zero on every error path
    assign result_valid        = valid_reg;
    assign item_out.status     = st_reg;
    assign item_out.data_out   = 32'(out_dat_reg);
    assign item_out.count      = 9'(count_reg);
    assign item_out.empty_flag = (count_reg == '0);
    assign item_out.is_full    = (count_reg >= cap_eff);

endmodule

// ===== hdl/bmhq_ctrl.sv =====
// sequencing state machine for the min-heap queue
module bmhq_ctrl import bmhq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  sts_t       sts,
    output ctl_t       ctl,
    output logic       busy
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_ROOT    = 4'd2;
    localparam logic [3:0] S_SCAN_CK = 4'd3;
    localparam logic [3:0] S_SCAN_RD = 4'd4;
    localparam logic [3:0] S_RM      = 4'd5;
    localparam logic [3:0] S_LAST    = 4'd6;
    localparam logic [3:0] S_RM_UP   = 4'd7;
    localparam logic [3:0] S_RM_PAR  = 4'd8;
    localparam logic [3:0] S_UP_CHK  = 4'd9;
    localparam logic [3:0] S_UP_CMP  = 4'd10;
    localparam logic [3:0] S_DN_L    = 4'd11;
    localparam logic [3:0] S_DN_R    = 4'd12;
    localparam logic [3:0] S_DN_CMP  = 4'd13;
    localparam logic [3:0] S_PLACE   = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            if (start && !busy)
                cmd_reg <= command;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (sts.full)
                            state_next = S_EMIT;
                        else
                        begin
                            ctl.init_push = 1'b1;
                            ctl.set_ok = 1'b1;
                            state_next = S_UP_CHK;
                        end
                    end
                    CMD_POP,
                    CMD_PEEK:
                    begin
                        if (sts.empty)
                            state_next = S_EMIT;
                        else
                        begin
                            ctl.rd_scan = 1'b1; // search pointer is 1: root
                            state_next = S_ROOT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (sts.empty)
                            state_next = S_EMIT;
                        else
                        begin
                            ctl.rd_scan = 1'b1;
                            state_next = S_SCAN_CK;
                        end
                    end
                    default: state_next = S_EMIT;
                endcase
            end
            S_ROOT:
            begin
                ctl.cap_out = 1'b1;
                ctl.set_ok = 1'b1;
                if (cmd_reg == CMD_POP)
                    state_next = S_RM; // removal of position 1
                else
                    state_next = S_EMIT;
            end
            S_SCAN_CK:
            begin
                if (sts.match)
                begin
                    ctl.cap_out = 1'b1;
                    ctl.set_ok = 1'b1;
                    state_next = S_RM;
                end
                else if (sts.scan_end)
                    state_next = S_EMIT;
                else
                begin
                    ctl.step_scan = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                ctl.rd_scan = 1'b1;
                state_next = S_SCAN_CK;
            end
            S_RM:
            begin
                // removal with the hole at the search pointer
                if (sts.rm_is_last)
                begin
                    ctl.init_rm = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.rd_last = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                ctl.cap_last = 1'b1;
                ctl.init_rm = 1'b1;
                state_next = S_RM_UP;
            end
            S_RM_UP:
            begin
                if (sts.hole_root)
                    state_next = S_DN_L;
                else
                begin
                    ctl.rd_parent = 1'b1;
                    state_next = S_RM_PAR;
                end
            end
            S_RM_PAR:
            begin
                if (sts.up_go)
                begin
                    ctl.move_parent = 1'b1;
                    state_next = S_UP_CHK;
                end
                else
                    state_next = S_DN_L;
            end
            S_UP_CHK:
            begin
                if (sts.hole_root)
                    state_next = S_PLACE;
                else
                begin
                    ctl.rd_parent = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_go)
                begin
                    ctl.move_parent = 1'b1;
                    state_next = S_UP_CHK;
                end
                else
                    state_next = S_PLACE;
            end
            S_DN_L:
            begin
                if (sts.has_left)
                begin
                    ctl.rd_left = 1'b1;
                    state_next = S_DN_R;
                end
                else
                    state_next = S_PLACE;
            end
            S_DN_R:
            begin
                ctl.cap_left = 1'b1;
                if (sts.has_right)
                    ctl.rd_right = 1'b1;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.down_go)
                begin
                    ctl.move_child = 1'b1;
                    state_next = S_DN_L;
                end
                else
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                ctl.place = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                ctl.emit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/binary_min_heap_queue.sv =====
// top level of the binary min-heap priority queue
// Usage: raise start with an item (command, priority, data) while busy is low.
// The block runs the command on its internal heap store, then shows one
// result for one cycle with result_valid high; the receiver cannot stall.
// Push sifts up; pop and delete refill the hole with the last entry and
// sift it up or down. Full or empty errors go straight to the result, peek
// reads only the root, and a pop that empties the block skips the refill.
// Delete searches the entries in order, then removes as pop does.
// busy drops in the cycle the result is shown, so the next item can be
// accepted at that cycle's edge; one item is in flight at a time.
// Reset clears the entry count and sets capacity to 256; store contents are
// left as they are, since only entries below the count are read.
// The capacity register sits at APB address 0; the user is to write it
// only while idle, as the block itself does not enforce it.
module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int DATA_BITS     = DATA_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_in_t    item_in,
    output logic        result_valid,
    output item_out_t   item_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    ctl_t ctl;
    sts_t sts;
    logic [8:0] capacity_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (psel && penable && pwrite && paddr == REG_CAPACITY)
            capacity_reg <= pwdata[8:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CAPACITY) ? {23'd0, capacity_reg} : '0;

    bmhq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(item_in.command),
        .sts(sts), .ctl(ctl), .busy(busy)
    );

    bmhq_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES), .PRIORITY_BITS(PRIORITY_BITS), .DATA_BITS(DATA_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .item_in(item_in),
        .capacity(capacity_reg), .item_out(item_out),
        .result_valid(result_valid)
    );

    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> !$past(result_valid))
        else $error("double result");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised");
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> !busy)
        else $error("result while busy");

endmodule
